[sv/primality_test_small_prime_filter_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the small-prime filter primality tester
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef PRIMALITY_TEST_SMALL_PRIME_FILTER_DEFINES_SVH
`define PRIMALITY_TEST_SMALL_PRIME_FILTER_DEFINES_SVH

// same-cycle implication
`define PTSPF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptspf assertion failed");

// next-cycle implication
`define PTSPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptspf assertion failed");

`endif

[sv/ptspf_pkg.sv]
// ----------------------------------------------------------------------------
// ptspf_pkg
// Types and constants shared by the small-prime filter primality tester.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptspf_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;

   localparam int SCREEN_COUNT    = 16;
   localparam int SCREEN_IDX_BITS = 4;
   localparam int PRIME_BITS      = 6;

   localparam logic [PRIME_BITS-1:0] SCREEN_PRIMES [SCREEN_COUNT] = '{
      6'd2,  6'd3,  6'd5,  6'd7,  6'd11, 6'd13, 6'd17, 6'd19,
      6'd23, 6'd29, 6'd31, 6'd37, 6'd41, 6'd43, 6'd47, 6'd53
   };

   // first odd divisor above the screen primes
   localparam int FIRST_TRIAL_DIVISOR = 59;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

[sv/ptspf_if.sv]
// ----------------------------------------------------------------------------
// ptspf channel interfaces
// Valid/ready channels for the value to test and for the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ptspf_req_if #(parameter int VALUE_BITS = ptspf_pkg::VALUE_BITS_DEFAULT) ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface ptspf_rsp_if ();
   logic valid;
   logic ready;
   logic is_prime;
   logic screened_out;

   modport source (output valid, output is_prime, output screened_out, input ready);
   modport sink   (input valid, input is_prime, input screened_out, output ready);
endinterface

[sv/ptspf_div.sv]
// ----------------------------------------------------------------------------
// ptspf_div
// Bit-serial restoring divider: one quotient bit per cycle, quotient and
// remainder valid while done is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptspf_div #(
   parameter int VALUE_BITS = ptspf_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [VALUE_BITS-1:0]   dividend,
   input  logic [VALUE_BITS-1:0]   divisor,
   output logic [VALUE_BITS-1:0]   quotient,
   output logic [VALUE_BITS-1:0]   remainder,
   output ptspf_pkg::div_stat_type stat
);
   import ptspf_pkg::*;

   localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   logic [VALUE_BITS-1:0] dsr_ff, dsr_in;

   logic [VALUE_BITS:0]   shifted;
   logic [VALUE_BITS:0]   diff;

   assign shifted = {rem_ff, quot_ff[VALUE_BITS-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_BITS'(VALUE_BITS);
         rem_in   = '0;
         quot_in  = dividend;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         // negative difference: restore
         if (diff[VALUE_BITS]) begin
            rem_in = shifted[VALUE_BITS-1:0];
         end else begin
            rem_in = diff[VALUE_BITS-1:0];
         end
         quot_in  = {quot_ff[VALUE_BITS-2:0], ~diff[VALUE_BITS]};
         count_in = count_ff - CNT_BITS'(1);
         if (count_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dsr_ff  <= dsr_in;
   end

   assign quotient  = quot_ff;
   assign remainder = rem_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

[sv/primality_test_small_prime_filter.sv]
// ----------------------------------------------------------------------------
// primality_test_small_prime_filter
// Primality tester: small-prime screen, then odd trial division, all
// divisions on one shared bit-serial divider.
// Usage:
//   req_ch carries one unsigned value per transaction; rsp_ch returns one
//   verdict per value, in order: is_prime, and screened_out when a prime
//   2..53 other than the value itself divides it.
//   req_ch.ready is high only while the sequencer is idle; one value is
//   worked on at a time.
//   The screen costs up to 16 divisions and stops at the first hit. Odd
//   values above 1 that pass it are tried against odd divisors from 59
//   while d <= value / d. The number n of trial divisors is near 32740 for
//   a 32-bit prime, while most composites finish within the screen.
//   The verdict sits in an output register; a new value is accepted while
//   it waits, and a later verdict holds in the sequencer until rsp drains.
//   Reset is synchronous: it clears the sequencer, divider control and
//   rsp_ch.valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "primality_test_small_prime_filter_defines.svh"

module primality_test_small_prime_filter #(
   parameter int VALUE_BITS = ptspf_pkg::VALUE_BITS_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   ptspf_req_if.sink    req_ch,
   ptspf_rsp_if.source  rsp_ch
);
   import ptspf_pkg::*;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_SCR_START = 3'd1;
   localparam logic [2:0] S_SCR_WAIT  = 3'd2;
   localparam logic [2:0] S_TRL_PRE   = 3'd3;
   localparam logic [2:0] S_TRL_START = 3'd4;
   localparam logic [2:0] S_TRL_WAIT  = 3'd5;
   localparam logic [2:0] S_FINISH    = 3'd6;

   logic [2:0]                 state_ff, state_in;
   logic [VALUE_BITS-1:0]      value_ff, value_in;
   logic [SCREEN_IDX_BITS-1:0] k_ff, k_in;
   logic [VALUE_BITS-1:0]      d_ff, d_in;
   logic                       prime_ff, prime_in;
   logic                       screened_ff, screened_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_prime_ff, rsp_prime_in;
   logic                       rsp_screened_ff, rsp_screened_in;

   logic                       div_start;
   logic [VALUE_BITS-1:0]      div_divisor;
   logic [VALUE_BITS-1:0]      div_quot;
   logic [VALUE_BITS-1:0]      div_rem;
   div_stat_type               div_stat;
   logic [VALUE_BITS-1:0]      cur_prime;
   logic                       out_free;

   assign cur_prime   = VALUE_BITS'(SCREEN_PRIMES[k_ff]);
   assign div_start   = (state_ff == S_SCR_START) || (state_ff == S_TRL_START);
   assign div_divisor = (state_ff == S_SCR_START) ? cur_prime : d_ff;
   assign out_free    = !rsp_valid_ff || rsp_ch.ready;

   ptspf_div #(.VALUE_BITS(VALUE_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (value_ff),
      .divisor   (div_divisor),
      .quotient  (div_quot),
      .remainder (div_rem),
      .stat      (div_stat)
   );

   always_comb begin
      state_in    = state_ff;
      value_in    = value_ff;
      k_in        = k_ff;
      d_in        = d_ff;
      prime_in    = prime_ff;
      screened_in = screened_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               value_in    = req_ch.value;
               k_in        = '0;
               prime_in    = 1'b0;
               screened_in = 1'b0;
               state_in    = S_SCR_START;
            end
         end
         S_SCR_START: begin
            state_in = S_SCR_WAIT;
         end
         S_SCR_WAIT: begin
            if (div_stat.done) begin
               if (div_rem == '0 && value_ff != cur_prime) begin
                  screened_in = 1'b1;
                  state_in    = S_FINISH;
               end else if (k_ff == SCREEN_IDX_BITS'(SCREEN_COUNT - 1)) begin
                  state_in = S_TRL_PRE;
               end else begin
                  k_in     = k_ff + SCREEN_IDX_BITS'(1);
                  state_in = S_SCR_START;
               end
            end
         end
         S_TRL_PRE: begin
            if (value_ff[VALUE_BITS-1:1] == '0) begin
               prime_in = 1'b0;
               state_in = S_FINISH;
            end else if (!value_ff[0]) begin
               prime_in = (value_ff == VALUE_BITS'(2));
               state_in = S_FINISH;
            end else begin
               // divisors through 53 are already covered by the screen
               d_in     = VALUE_BITS'(FIRST_TRIAL_DIVISOR);
               state_in = S_TRL_START;
            end
         end
         S_TRL_START: begin
            state_in = S_TRL_WAIT;
         end
         S_TRL_WAIT: begin
            if (div_stat.done) begin
               if (d_ff > div_quot) begin
                  prime_in = 1'b1;
                  state_in = S_FINISH;
               end else if (div_rem == '0) begin
                  prime_in = 1'b0;
                  state_in = S_FINISH;
               end else begin
                  d_in     = d_ff + VALUE_BITS'(2);
                  state_in = S_TRL_START;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_prime_in    = rsp_prime_ff;
      rsp_screened_in = rsp_screened_ff;
      if (state_ff == S_FINISH && out_free) begin
         rsp_valid_in    = 1'b1;
         rsp_prime_in    = prime_ff;
         rsp_screened_in = screened_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff        <= value_in;
      k_ff            <= k_in;
      d_ff            <= d_in;
      prime_ff        <= prime_in;
      screened_ff     <= screened_in;
      rsp_prime_ff    <= rsp_prime_in;
      rsp_screened_ff <= rsp_screened_in;
   end

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.is_prime     = rsp_prime_ff;
   assign rsp_ch.screened_out = rsp_screened_ff;

   `PTSPF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   `PTSPF_ASSERT_IMPL(a_screen_not_prime, clock, reset, rsp_ch.valid && rsp_ch.screened_out, !rsp_ch.is_prime)
   `PTSPF_ASSERT_IMPL(a_done_in_wait, clock, reset, div_stat.done, state_ff == S_SCR_WAIT || state_ff == S_TRL_WAIT)
   `PTSPF_ASSERT_IMPL(a_start_when_free, clock, reset, div_start, !div_stat.busy)

endmodule
